// File: rtl/core/slwl_pkg.sv
package slwl_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned MAXREQ_W = 9;
  localparam int unsigned OUTCNT_W = 9;
  localparam int unsigned CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_NS    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE
  } seq_state_e;

endpackage

// File: rtl/core/slwl_ring.sv
module slwl_ring #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [slwl_pkg::TIME_W-1:0]  wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [slwl_pkg::TIME_W-1:0]  rdata_o
);

  logic [slwl_pkg::TIME_W-1:0] mem [DEPTH];
  logic [slwl_pkg::TIME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/slwl_seq.sv
module slwl_seq #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned CW    = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [slwl_pkg::TIME_W-1:0]    request_time_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           allowed_o,
  output logic [slwl_pkg::OUTCNT_W-1:0]  window_count_o,
  input  logic [CW-1:0]                  limit_i,
  input  logic [slwl_pkg::TIME_W-1:0]    window_i,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [slwl_pkg::TIME_W-1:0]    mem_wdata_o,
  output logic                           mem_re_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [slwl_pkg::TIME_W-1:0]    mem_rdata_i,
  output logic [CW-1:0]                  count_o
);

  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
  endfunction

  slwl_pkg::seq_state_e state_q, state_d;

  logic [slwl_pkg::TIME_W-1:0]   now_q, now_d;
  logic [AW-1:0]                 head_q, head_d;
  logic [AW-1:0]                 tail_q, tail_d;
  logic [CW-1:0]                 count_q, count_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_allowed_q, out_allowed_d;
  logic [slwl_pkg::OUTCNT_W-1:0] out_count_q, out_count_d;

  logic [slwl_pkg::TIME_W-1:0] age;
  logic                        expire;
  logic                        out_free;
  logic                        allow;
  logic                        do_decide;

  // shared unit: one wrapping subtract and compare per cycle
  assign age      = now_q - mem_rdata_i;
  assign expire   = age > window_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign allow    = count_q < limit_i;

  always_comb begin
    state_d       = state_q;
    now_d         = now_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_allowed_d = out_allowed_q;
    out_count_d   = out_count_q;
    mem_re_o      = 1'b0;
    mem_raddr_o   = head_q;
    do_decide     = 1'b0;
    in_ready_o    = 1'b0;

    unique case (state_q)
      slwl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          now_d = request_time_i;
          if (count_q != '0) begin
            mem_re_o = 1'b1;
            state_d  = slwl_pkg::ST_CHECK;
          end else begin
            state_d = slwl_pkg::ST_DECIDE;
          end
        end
      end
      slwl_pkg::ST_CHECK: begin
        if (expire) begin
          head_d  = idx_inc(head_q);
          count_d = count_q - 1'b1;
          if (count_q == CW'(1)) begin
            state_d = slwl_pkg::ST_DECIDE;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = idx_inc(head_q);
          end
        end else if (out_free) begin
          do_decide = 1'b1;
        end else begin
          state_d = slwl_pkg::ST_DECIDE;
        end
      end
      slwl_pkg::ST_DECIDE: begin
        do_decide = out_free;
      end
      default: begin
        state_d = slwl_pkg::ST_IDLE;
      end
    endcase

    if (do_decide) begin
      state_d       = slwl_pkg::ST_IDLE;
      out_valid_d   = 1'b1;
      out_allowed_d = allow;
      if (allow) begin
        tail_d  = idx_inc(tail_q);
        count_d = count_q + 1'b1;
      end
      out_count_d = slwl_pkg::OUTCNT_W'(allow ? count_q + 1'b1 : count_q);
    end
  end

  assign mem_we_o    = do_decide && allow;
  assign mem_waddr_o = tail_q;
  assign mem_wdata_o = now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= slwl_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q         <= now_d;
    out_allowed_q <= out_allowed_d;
    out_count_q   <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign allowed_o      = out_allowed_q;
  assign window_count_o = out_count_q;
  assign count_o        = count_q;

endmodule

// File: rtl/core/sliding_window_log_rate_limiter.sv
// Sequence: after a request is taken in IDLE, CHECK pops expired entries one per cycle
// through the shared 64-bit subtract/compare (skipped when the log is empty); the result
// is registered from CHECK or DECIDE once the previous result is leaving the output.
// Requests: the next request is taken the cycle after the result is registered,
// also while that result waits at the output; one request is in work at a time.
// Reset: asynchronous; clears pointers, count, config and output valid, not the ring.
module sliding_window_log_rate_limiter #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [slwl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [slwl_pkg::TIME_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [slwl_pkg::TIME_W-1:0]       request_time_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              allowed_o,
  output logic [slwl_pkg::OUTCNT_W-1:0]     window_count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > slwl_pkg::MAXREQ_W) ? CW : slwl_pkg::MAXREQ_W;
  localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

  logic [slwl_pkg::MAXREQ_W-1:0] max_req_q;
  logic [slwl_pkg::TIME_W-1:0]   window_q;
  logic [KW-1:0]                 max_req_k;
  logic [KW-1:0]                 limit_k;
  logic [CW-1:0]                 limit;
  logic [CW-1:0]                 count;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [slwl_pkg::TIME_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [slwl_pkg::TIME_W-1:0] mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_req_q <= '0;
      window_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slwl_pkg::REG_MAX_REQUESTS: max_req_q <= cfg_wdata_i[slwl_pkg::MAXREQ_W-1:0];
        slwl_pkg::REG_WINDOW_NS:    window_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // limit saturates at the ring depth
  assign max_req_k = KW'(max_req_q);
  assign limit_k   = (max_req_k > DEPTH_K) ? DEPTH_K : max_req_k;
  assign limit     = limit_k[CW-1:0];

  slwl_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .request_time_i (request_time_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .allowed_o      (allowed_o),
    .window_count_o (window_count_o),
    .limit_i        (limit),
    .window_i       (window_q),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata),
    .count_o        (count)
  );

  slwl_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    KW'(count) <= DEPTH_K)
    else $error("log count above depth");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while previous one in work");

  a_allowed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && allowed_o |-> (DEPTH > 511) || (window_count_o != '0))
    else $error("allowed request with empty log");

  a_ring_write_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> KW'(count) < limit_k)
    else $error("ring written at or above limit");

endmodule

// File: bench/sliding_window_log_rate_limiter_tb.sv
module sliding_window_log_rate_limiter_tb;

  localparam int unsigned DEPTH          = 256;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_AT        = 500;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef struct packed {
    logic                          allowed;
    logic [slwl_pkg::OUTCNT_W-1:0] window_count;
  } verdict_t;

  // Tracks the timestamp log and the verdict each request should get.
  class rate_log_tracker;
    logic [slwl_pkg::TIME_W-1:0]   stamps [DEPTH];
    int unsigned                   oldest;
    int unsigned                   logged;
    logic [slwl_pkg::MAXREQ_W-1:0] max_requests;
    logic [slwl_pkg::TIME_W-1:0]   window_ns;
    verdict_t                      verdict_q [$];
    int unsigned                   errors;

    function new();
      oldest       = 0;
      logged       = 0;
      max_requests = '0;
      window_ns    = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [slwl_pkg::CFG_IDX_W-1:0] idx,
                            logic [slwl_pkg::TIME_W-1:0]    data);
      if (idx == slwl_pkg::REG_MAX_REQUESTS) begin
        max_requests = data[slwl_pkg::MAXREQ_W-1:0];
      end else if (idx == slwl_pkg::REG_WINDOW_NS) begin
        window_ns = data;
      end
    endfunction

    function void log_request(logic [slwl_pkg::TIME_W-1:0] now);
      int unsigned                 limit;
      logic [slwl_pkg::TIME_W-1:0] age;
      bit                          expiring;
      verdict_t                    v;
      limit    = (max_requests > DEPTH) ? DEPTH : max_requests;
      expiring = 1'b1;
      while (logged > 0 && expiring) begin
        // wrapping age: entries "in the future" look very old
        age = now - stamps[oldest];
        if (age > window_ns) begin
          oldest = (oldest + 1) % DEPTH;
          logged--;
        end else begin
          expiring = 1'b0;
        end
      end
      v.allowed = 1'b0;
      if (logged < limit) begin
        stamps[(oldest + logged) % DEPTH] = now;
        logged++;
        v.allowed = 1'b1;
      end
      v.window_count = logged[slwl_pkg::OUTCNT_W-1:0];
      verdict_q = {verdict_q, v};
    endfunction

    function void check_result(logic allowed, logic [slwl_pkg::OUTCNT_W-1:0] count);
      verdict_t v;
      if (verdict_q.size() == 0) begin
        $error("unexpected result: allowed=%0d window_count=%0d", allowed, count);
        errors++;
        return;
      end
      v = verdict_q.pop_front();
      if (allowed !== v.allowed) begin
        $error("allowed: expected %0d, actual %0d", v.allowed, allowed);
        errors++;
      end
      if (count !== v.window_count) begin
        $error("window_count: expected %0d, actual %0d", v.window_count, count);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           cfg_we       = 1'b0;
  logic [slwl_pkg::CFG_IDX_W-1:0] cfg_idx      = '0;
  logic [slwl_pkg::TIME_W-1:0]    cfg_wdata    = '0;
  logic                           in_valid     = 1'b0;
  logic                           in_ready;
  logic [slwl_pkg::TIME_W-1:0]    request_time = '0;
  logic                           out_valid;
  logic                           out_ready    = 1'b0;
  logic                           allowed;
  logic [slwl_pkg::OUTCNT_W-1:0]  window_count;

  bit                             idle_on = 1'b1;
  logic [slwl_pkg::TIME_W-1:0]    now_t   = '0;
  rate_log_tracker                rate_log = new();

  sliding_window_log_rate_limiter #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .request_time_i (request_time),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .allowed_o      (allowed),
    .window_count_o (window_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [slwl_pkg::TIME_W-1:0] step_time(
      logic [slwl_pkg::TIME_W-1:0] cur,
      logic [slwl_pkg::TIME_W-1:0] w);
    case ($urandom_range(0, 19))
      0, 1, 2, 3: return cur;
      4:          return cur + w;
      5:          return cur + w + 1;
      6:          return cur - $urandom_range(1, 64);   // time going backwards
      7:          return cur + {$urandom, $urandom};
      default:    return cur + (w >> $urandom_range(1, 8)) + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_request(input logic [slwl_pkg::TIME_W-1:0] t);
    while (idle_on && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    request_time <= t;
    do @(posedge clk); while (!in_ready);
    rate_log.log_request(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rate_log.pending() != 0) @(posedge clk);
  endtask

  task automatic configure(input logic [slwl_pkg::MAXREQ_W-1:0] max_req,
                           input logic [slwl_pkg::TIME_W-1:0]   window);
    logic [slwl_pkg::TIME_W-1:0] data;
    // upper bits of the limit write are don't-care; toggle them anyway
    data                         = {$urandom, $urandom};
    data[slwl_pkg::MAXREQ_W-1:0] = max_req;
    cfg_we    <= 1'b1;
    cfg_idx   <= slwl_pkg::REG_MAX_REQUESTS;
    cfg_wdata <= data;
    @(posedge clk);
    rate_log.write_reg(slwl_pkg::REG_MAX_REQUESTS, data);
    cfg_idx   <= slwl_pkg::REG_WINDOW_NS;
    cfg_wdata <= window;
    @(posedge clk);
    rate_log.write_reg(slwl_pkg::REG_WINDOW_NS, window);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int n, input logic [slwl_pkg::TIME_W-1:0] window,
                           input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      now_t = step_time(now_t, window);
      send_request(now_t);
    end
    drain();
  endtask

  // result side: random backpressure plus one long hold-off
  initial begin
    int unsigned seen;
    int unsigned hold;
    seen = 0;
    hold = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        rate_log.check_result(allowed, window_count);
        seen++;
        if (seen == HOLD_AT) hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= !idle_on || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [slwl_pkg::TIME_W-1:0] w;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: limit zero denies everything
    send_request('0);
    send_request('1);
    drain();

    // zero window: only equal timestamps survive
    configure(1, 0);
    send_request(5);
    send_request(5);
    send_request(6);
    drain();

    configure(3, 10);
    send_request(100);
    send_request(105);
    send_request(110);
    send_request(110);
    send_request(111);
    send_request(50);
    send_request(64'hFFFF_FFFF_FFFF_FFFC);
    send_request(2);      // wraps forward past zero
    drain();

    // limit lowered below the current count
    configure(8, '1);
    for (int i = 0; i < 6; i++) send_request(1000 + i);
    drain();
    configure(2, '1);
    send_request(1010);
    drain();

    now_t = 2000;
    configure($urandom_range(1, 16), 100);
    run_phase(150, 100, -1);

    idle_on = 1'b0;
    configure(256, 2000);
    run_phase(200, 2000, -1);
    idle_on = 1'b1;

    // limit above depth saturates; full window never expires
    configure(9'h1FF, '1);
    run_phase(300, '1, -1);

    configure($urandom_range(0, 300), 0);
    run_phase(100, 0, -1);

    w = {$urandom, $urandom} >> $urandom_range(0, 63);
    configure($urandom_range(0, 511), w);
    run_phase(150, w, -1);

    configure(5, 1000);
    run_phase(200, 1000, 100);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (rate_log.errors == 0 && rate_log.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
